// ----- rtl/lrt_pkg.sv -----
package lrt_pkg;

  // Key and reported occupancy widths
  localparam int unsigned KeyW = 32;
  localparam int unsigned OccW = 3;

  // Per-cell control from the top level
  typedef struct packed {
    logic load;   // a word is being accepted this cycle
    logic valid;  // cell position lies below the current fill
  } cell_ctl_t;

endpackage

// ----- rtl/lrt_cell.sv -----
module lrt_cell (
  input  logic                             clk_i,
  input  lrt_pkg::cell_ctl_t               ctl_i,
  input  logic signed [lrt_pkg::KeyW-1:0]  access_key_i,
  input  logic signed [lrt_pkg::KeyW-1:0]  prev_key_i,
  input  logic                             seen_i,
  output logic signed [lrt_pkg::KeyW-1:0]  key_o,
  output logic                             seen_o
);

  logic signed [lrt_pkg::KeyW-1:0] key_q, key_d;
  logic                            match;

  // Tag compare against the access key
  assign match  = ctl_i.valid && (key_q == access_key_i);
  assign seen_o = seen_i | match;

  // Shift in from the neighbor unless the hit sits ahead of this cell
  always_comb begin
    key_d = key_q;
    if (ctl_i.load && !seen_i) begin
      key_d = prev_key_i;
    end
  end

  // Key storage, no reset: fill count marks what is valid
  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o = key_q;

endmodule

// ----- rtl/lru_recency_tracker_core.sv -----
// LRU recency tracker.
// Keeps up to ENTRIES distinct 32-bit keys in recency order, most recent
// first, in a row of cells that each hold one key and compare it with the
// access key. A hit moves the key to the front; a miss inserts it at the
// front and, when the row is full, drops the least recent key.
// Command channel: a word (access_key_i) is taken at a rising edge where
// start is high and busy is low. busy stays low: a new word can be
// given in every cycle.
// Result channel: in the cycle after the accept, done_o is high for exactly one
// cycle with hit_o, evicted_o, evicted_key_o (zero without eviction) and
// occupancy_o (count after the access, modulo 8). The receiver cannot stall.
// Throughput 1 word per cycle; the compare and hit-position chain runs
// through all ENTRIES cells combinationally.
// Reset (rst_ni low, async) empties the list and clears done_o; key storage
// is not cleared, the fill count alone marks valid cells.
module lru_recency_tracker_core #(
  parameter int unsigned ENTRIES = 4
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [lrt_pkg::KeyW-1:0]  access_key_i,
  output logic                             done_o,
  output logic                             hit_o,
  output logic                             evicted_o,
  output logic signed [lrt_pkg::KeyW-1:0]  evicted_key_o,
  output logic        [lrt_pkg::OccW-1:0]  occupancy_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic                            accept;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            full;
  logic                            hit;
  logic signed [lrt_pkg::KeyW-1:0] key_chain  [ENTRIES+1];
  logic                            seen_chain [ENTRIES+1];

  logic                            done_q;
  logic                            hit_q, evicted_q;
  logic signed [lrt_pkg::KeyW-1:0] evicted_key_q;
  logic [lrt_pkg::OccW-1:0]        occ_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign full   = (cnt_q == CntW'(ENTRIES));

  // Chain heads: cell 0 takes the access key, nothing seen ahead of it
  assign key_chain[0]  = access_key_i;
  assign seen_chain[0] = 1'b0;

  // Row of cells
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lrt_pkg::cell_ctl_t ctl;
    assign ctl.load  = accept;
    assign ctl.valid = (CntW'(i) < cnt_q);

    lrt_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .access_key_i (access_key_i),
      .prev_key_i   (key_chain[i]),
      .seen_i       (seen_chain[i]),
      .key_o        (key_chain[i+1]),
      .seen_o       (seen_chain[i+1])
    );
  end

  assign hit = seen_chain[ENTRIES];

  // Fill count update
  always_comb begin
    cnt_d = cnt_q;
    if (accept && !hit && !full) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= accept;
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hit_q         <= hit;
      evicted_q     <= !hit && full;
      evicted_key_q <= (!hit && full) ? key_chain[ENTRIES] : '0;
      occ_q         <= lrt_pkg::OccW'(cnt_d);
    end
  end

  assign done_o        = done_q;
  assign hit_o         = hit_q;
  assign evicted_o     = evicted_q;
  assign evicted_key_o = evicted_key_q;
  assign occupancy_o   = occ_q;

endmodule

// ----- rtl/lrt_checker.sv -----
module lrt_checker #(
  parameter int unsigned ENTRIES = 4
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             start,
  input logic                             busy,
  input logic                             done_o,
  input logic                             hit_o,
  input logic                             evicted_o,
  input logic signed [lrt_pkg::KeyW-1:0]  evicted_key_o,
  input logic        [lrt_pkg::OccW-1:0]  occupancy_o
);

  // A result word in the cycle after each accepted word
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o) else $error("missing result word");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o) else $error("result word without command");

  // A hit never evicts
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !(hit_o && evicted_o)) else $error("hit and eviction together");

  // Eviction only with the list full
  a_evict_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && evicted_o) |-> (occupancy_o == lrt_pkg::OccW'(ENTRIES)))
    else $error("eviction below full occupancy");

  // Evicted key reads zero without eviction
  a_key_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !evicted_o) |-> (evicted_key_o == '0))
    else $error("evicted key nonzero without eviction");

endmodule

bind lru_recency_tracker_core lrt_checker #(.ENTRIES(ENTRIES)) u_lrt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .hit_o         (hit_o),
  .evicted_o     (evicted_o),
  .evicted_key_o (evicted_key_o),
  .occupancy_o   (occupancy_o)
);

// ----- sim/tb_lru_recency_tracker_core.sv -----
module tb_lru_recency_tracker_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned KeyW      = lrt_pkg::KeyW;
  localparam int unsigned OccW      = lrt_pkg::OccW;

  localparam int unsigned Depth     = 4;
  localparam int unsigned NumDir    = 20;
  localparam int unsigned NumRand   = 500;
  localparam int unsigned QuietTail = 80;
  localparam int unsigned IdleLimit = 200;

  // One access outcome as the block reports it
  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [KeyW-1:0]   evicted_key;
    logic [OccW-1:0]   occupancy;
  } access_outcome_t;

  // Directed word: key, whether the outcome is given by hand, and that outcome
  typedef struct packed {
    logic [KeyW-1:0] key;
    logic            typed;
    access_outcome_t want;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic signed [KeyW-1:0] access_key_i;
  logic                   done_o;
  logic                   hit_o;
  logic                   evicted_o;
  logic signed [KeyW-1:0] evicted_key_o;
  logic        [OccW-1:0] occupancy_o;

  // Hand-given outcome that travels with the word on the bus
  logic            word_typed;
  access_outcome_t word_want;

  // Predictor state: recency order, most recent at index 0
  logic [KeyW-1:0] lru_keys [Depth];
  int unsigned     lru_fill;

  access_outcome_t outcome_q [$];
  int unsigned     errors;
  int unsigned     idle_cycles;

  // Extremes, the special cases below, then near-miss keys
  dir_row_t dir_rows [NumDir] = '{
    '{32'h0000_0000, 1'b1, '{1'b0, 1'b0, 32'h0000_0000, 3'd1}},
    '{32'h7FFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'h0000_0000, 3'd2}},
    '{32'h8000_0000, 1'b1, '{1'b0, 1'b0, 32'h0000_0000, 3'd3}},
    '{32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'h0000_0000, 3'd4}},
    // hit on the front key
    '{32'hFFFF_FFFF, 1'b1, '{1'b1, 1'b0, 32'h0000_0000, 3'd4}},
    // hit on the least recent key while full
    '{32'h0000_0000, 1'b1, '{1'b1, 1'b0, 32'h0000_0000, 3'd4}},
    // misses while full drop the tail
    '{32'h5555_5555, 1'b1, '{1'b0, 1'b1, 32'h7FFF_FFFF, 3'd4}},
    '{32'hAAAA_AAAA, 1'b1, '{1'b0, 1'b1, 32'h8000_0000, 3'd4}},
    '{32'h0000_0000, 1'b0, '0},
    '{32'h0000_0001, 1'b0, '0},
    '{32'h5555_5554, 1'b0, '0},
    '{32'hAAAA_AAAA, 1'b0, '0},
    '{32'h0000_0001, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'h7FFF_FFFE, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, '0},
    '{32'h8000_0001, 1'b0, '0},
    '{32'h1234_5678, 1'b0, '0},
    '{32'h1234_5678, 1'b0, '0},
    '{32'hFEDC_BA98, 1'b0, '0}
  };

  lru_recency_tracker_core #(
    .ENTRIES(Depth)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .access_key_i (access_key_i),
    .done_o       (done_o),
    .hit_o        (hit_o),
    .evicted_o    (evicted_o),
    .evicted_key_o(evicted_key_o),
    .occupancy_o  (occupancy_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Apply one access to the predictor and return what the block should report
  function automatic access_outcome_t lru_touch(logic [KeyW-1:0] key);
    access_outcome_t res;
    int              pos;
    int unsigned     last;
    res = '0;
    pos = -1;
    for (int unsigned i = 0; i < lru_fill; i++) begin
      if (pos < 0 && lru_keys[i] == key) pos = i;
    end
    if (pos >= 0) begin
      res.hit = 1'b1;
      last    = pos;
    end else if (lru_fill >= Depth) begin
      res.evicted     = 1'b1;
      res.evicted_key = lru_keys[Depth-1];
      last            = Depth - 1;
    end else begin
      last     = lru_fill;
      lru_fill = lru_fill + 1;
    end
    for (int unsigned i = last; i > 0; i--) lru_keys[i] = lru_keys[i-1];
    lru_keys[0]   = key;
    res.occupancy = OccW'(lru_fill);
    return res;
  endfunction

  function automatic void check_field(string name, logic [KeyW-1:0] want,
                                      logic [KeyW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  // Result check against the oldest outcome, then capture of accepted words
  always @(posedge clk_i) begin : monitor
    access_outcome_t want;
    logic            moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (done_o) begin
        moved = 1'b1;
        if (outcome_q.size() == 0) begin
          $display("%0t: result with none expected, got hit %b evicted %b key %h occ %0d",
                   $time, hit_o, evicted_o, evicted_key_o, occupancy_o);
          errors++;
        end else begin
          want = outcome_q.pop_front();
          check_field("hit", KeyW'(want.hit), KeyW'(hit_o));
          check_field("evicted", KeyW'(want.evicted), KeyW'(evicted_o));
          check_field("evicted_key", want.evicted_key, evicted_key_o);
          check_field("occupancy", KeyW'(want.occupancy), KeyW'(occupancy_o));
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        want  = lru_touch(access_key_i);
        outcome_q.push_back(word_typed ? word_want : want);
      end
      // watchdog on cycles where nothing moves
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t: timeout, %0d results outstanding", $time, outcome_q.size());
          $display("tb_lru_recency_tracker_core: done, errors");
          $finish;
        end
      end
    end
  end

  // Present one word and hold it until the block takes it
  task automatic send_word(logic [KeyW-1:0] key, logic typed, access_outcome_t want);
    start        <= 1'b1;
    access_key_i <= key;
    word_typed   <= typed;
    word_want    <= want;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_burst(int unsigned cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain_outcomes();
    start <= 1'b0;
    do @(posedge clk_i); while (outcome_q.size() != 0);
  endtask

  // Stimulus
  initial begin : stimulus
    logic [KeyW-1:0] hot_keys [8];
    int unsigned     hot_n;
    int unsigned     pick;
    logic [KeyW-1:0] key;
    bit              gaps_on;
    rst_ni       = 1'b0;
    start        = 1'b0;
    access_key_i = '0;
    word_typed   = 1'b0;
    word_want    = '0;
    errors       = 0;
    idle_cycles  = 0;
    lru_fill     = 0;
    hot_n        = 4;
    gaps_on      = 1'b1;
    for (int i = 0; i < Depth; i++) lru_keys[i] = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].key, dir_rows[i].typed, dir_rows[i].want);
      if ($urandom_range(0, 3) == 0) idle_burst($urandom_range(1, 13));
    end
    drain_outcomes();

    // random words, mostly from a small working set so hits and evictions mix
    for (int unsigned n = 0; n < NumRand; n++) begin
      if (n % 40 == 0) begin
        hot_n = $urandom_range(3, 8);
        for (int j = 0; j < 8; j++) hot_keys[j] = $urandom;
      end
      if (n % 25 == 0) gaps_on = ($urandom_range(0, 2) != 0);
      if (n == 150 || n == 320) drain_outcomes();
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        key = hot_keys[$urandom_range(0, hot_n - 1)];
      end else if (pick < 80) begin
        key = hot_keys[$urandom_range(0, hot_n - 1)] ^ (32'h1 << $urandom_range(0, 31));
      end else if (pick < 90) begin
        case ($urandom_range(0, 3))
          0:       key = 32'h0000_0000;
          1:       key = 32'hFFFF_FFFF;
          2:       key = 32'h8000_0000;
          default: key = 32'h7FFF_FFFF;
        endcase
      end else begin
        key = $urandom;
      end
      send_word(key, 1'b0, '0);
      if (gaps_on && n < NumRand - QuietTail && $urandom_range(0, 3) == 0)
        idle_burst($urandom_range(1, 13));
    end

    // wind down
    drain_outcomes();
    repeat (4) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_lru_recency_tracker_core: done, clean");
    end else begin
      $display("tb_lru_recency_tracker_core: done, errors");
    end
    $finish;
  end

endmodule
